FILE: rtl/buddy_page_allocator_assert.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BPA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define BPA_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, controller states, datapath commands and status bundle.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int OW     = 4;
	localparam int PAGE_W = 10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_DISPATCH, ST_A_SEARCH, ST_A_HEAD,
		ST_UL_RD, ST_UL_FIX, ST_UL_CLR, ST_SPLIT, ST_PUSH1, ST_PUSH2,
		ST_F_RD, ST_F_CHK, ST_M_RD, ST_M_CHK, ST_M_UPD, ST_F_FINAL,
		ST_MARK, ST_RESULT, ST_FAIL
	} st_t;

	typedef enum logic [4:0] {
		CMD_INIT, CMD_IDLE, CMD_NOP, CMD_A_SEARCH, CMD_A_HEAD,
		CMD_UL_RD, CMD_UL_FIX, CMD_UL_CLR, CMD_SPLIT, CMD_PUSH1, CMD_PUSH2,
		CMD_F_RD, CMD_M_RD, CMD_F_CHK, CMD_M_UPD, CMD_F_FINAL,
		CMD_MARK, CMD_RESULT, CMD_FAIL
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic init_last;
		logic alloc_fail;
		logic page_ok;
		logic blk_ok;
		logic merge_try;
		logic buddy_ok;
		logic split_more;
		logic mark_last;
		logic out_room;
	} sts_t;

endpackage

FILE: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Buddy page allocator RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences initialisation, allocation, freeing and result transfer.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t cmd,
	output logic          req_stall
);
	import bpa_pkg::*;

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:     state_d = sts.init_last ? ST_IDLE : ST_INIT;
			ST_IDLE:     state_d = req_valid ? ST_DISPATCH : ST_IDLE;
			ST_DISPATCH: state_d = sts.op_free ? ST_F_RD : ST_A_SEARCH;
			ST_A_SEARCH: state_d = sts.alloc_fail ? ST_FAIL : ST_A_HEAD;
			ST_A_HEAD:   state_d = ST_UL_RD;
			ST_UL_RD:    state_d = ST_UL_FIX;
			ST_UL_FIX:   state_d = ST_UL_CLR;
			ST_UL_CLR:   state_d = sts.op_free ? ST_M_UPD : ST_SPLIT;
			ST_SPLIT:    state_d = sts.split_more ? ST_PUSH1 : ST_MARK;
			ST_PUSH1:    state_d = ST_PUSH2;
			ST_PUSH2:    state_d = sts.op_free ? ST_MARK : ST_SPLIT;
			ST_F_RD:     state_d = sts.page_ok ? ST_F_CHK : ST_FAIL;
			ST_F_CHK:    state_d = sts.blk_ok ? ST_M_RD : ST_FAIL;
			ST_M_RD:     state_d = sts.merge_try ? ST_M_CHK : ST_F_FINAL;
			ST_M_CHK:    state_d = sts.buddy_ok ? ST_UL_RD : ST_F_FINAL;
			ST_M_UPD:    state_d = ST_M_RD;
			ST_F_FINAL:  state_d = ST_PUSH1;
			ST_MARK:     state_d = sts.mark_last ? ST_RESULT : ST_MARK;
			ST_RESULT:   state_d = sts.out_room ? ST_IDLE : ST_RESULT;
			ST_FAIL:     state_d = sts.out_room ? ST_IDLE : ST_FAIL;
			default:     state_d = ST_INIT;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		cmd       = CMD_NOP;
		case (state_q)
			ST_INIT:     cmd = CMD_INIT;
			ST_IDLE: begin
				cmd       = CMD_IDLE;
				req_stall = 1'b0;
			end
			ST_A_SEARCH: cmd = CMD_A_SEARCH;
			ST_A_HEAD:   cmd = CMD_A_HEAD;
			ST_UL_RD:    cmd = CMD_UL_RD;
			ST_UL_FIX:   cmd = CMD_UL_FIX;
			ST_UL_CLR:   cmd = CMD_UL_CLR;
			ST_SPLIT:    cmd = CMD_SPLIT;
			ST_PUSH1:    cmd = CMD_PUSH1;
			ST_PUSH2:    cmd = CMD_PUSH2;
			ST_F_RD:     cmd = CMD_F_RD;
			ST_F_CHK:    cmd = CMD_F_CHK;
			ST_M_RD:     cmd = CMD_M_RD;
			ST_M_UPD:    cmd = CMD_M_UPD;
			ST_F_FINAL:  cmd = CMD_F_FINAL;
			ST_MARK:     cmd = CMD_MARK;
			ST_RESULT:   cmd = CMD_RESULT;
			ST_FAIL:     cmd = CMD_FAIL;
			default:     cmd = CMD_NOP;
		endcase
	end
endmodule

FILE: rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Page memories, free list heads and tails, work registers and result register.
// ----------------------------------------------------------------------------
module bpa_dp #(
	parameter int NUM_PAGES  = 1024,
	parameter int NUM_ORDERS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpa_pkg::cmd_t                cmd,
	output bpa_pkg::sts_t                sts,
	input  logic                         req_valid,
	input  logic                         opcode,
	input  logic [bpa_pkg::OW-1:0]       req_order,
	input  logic [bpa_pkg::PAGE_W-1:0]   page_index,
	input  logic                         rsp_stall,
	output logic                         rsp_valid,
	output logic                         ok,
	output logic [bpa_pkg::PAGE_W-1:0]   block_page,
	output logic [bpa_pkg::OW-1:0]       block_order
);
	import bpa_pkg::*;

	localparam int PW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int LW      = PW + 1;
	localparam int CW      = $clog2(NUM_PAGES + 1);
	localparam int OIW     = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int TOP     = NUM_ORDERS - 1;
	localparam int BLK     = 1 << TOP;
	localparam int NBLK    = NUM_PAGES >> TOP;
	localparam int COVERED = NBLK * BLK;
	localparam logic [LW-1:0] NIL = {1'b1, {PW{1'b0}}};

	logic          op_q;
	logic [OW-1:0] req_q;
	logic          pok_q;
	logic [PW-1:0] pg_q, tgt_q, cnt_q, init_q;
	logic [OW-1:0] ord_q;
	logic [LW-1:0] first_q [NUM_ORDERS];
	logic [LW-1:0] last_q  [NUM_ORDERS];
	logic [CW-1:0] count_q [NUM_ORDERS];
	logic          rsp_valid_q, ok_q;
	logic [PAGE_W-1:0] page_q;
	logic [OW-1:0] order_q;

	logic          fr_we, fr_wd, fr_rd;
	logic [PW-1:0] fr_wa, fo_ra;
	logic          or_we;
	logic [OW:0]   or_wd, or_rd;
	logic [PW-1:0] or_wa;
	logic          nx_we, pv_we;
	logic [PW-1:0] nx_wa, pv_wa;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

	logic [PW-1:0]  buddy, right, mark_addr;
	logic [OIW-1:0] lo;
	logic [LW-1:0]  tail;
	logic           found;
	logic [OW-1:0]  found_ord;
	logic           in_cov, is_head;
	logic [LW-1:0]  init_next, init_prev;

	bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_free_ram (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fo_ra), .rdata(fr_rd)
	);
	bpa_ram #(.WIDTH(OW + 1), .DEPTH(NUM_PAGES)) u_ord_ram (
		.clk(clk), .we(or_we), .waddr(or_wa), .wdata(or_wd), .raddr(fo_ra), .rdata(or_rd)
	);
	bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(tgt_q), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(tgt_q), .rdata(pv_rd)
	);

	assign buddy     = pg_q ^ (PW'(1) << ord_q);
	assign right     = pg_q + (PW'(1) << (ord_q - OW'(1)));
	assign mark_addr = pg_q + cnt_q;
	assign lo        = ord_q[OIW-1:0];
	assign tail      = last_q[lo];
	assign fo_ra     = (cmd == CMD_M_RD) ? buddy : pg_q;

	assign in_cov    = int'(init_q) < COVERED;
	assign is_head   = in_cov && ((int'(init_q) & (BLK - 1)) == 0);
	assign init_next = (is_head && (int'(init_q) + BLK < COVERED)) ?
		{1'b0, init_q + PW'(BLK)} : NIL;
	assign init_prev = (is_head && (int'(init_q) >= BLK)) ?
		{1'b0, init_q - PW'(BLK)} : NIL;

	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
			if (count_q[k] != '0 && k >= int'(req_q)) begin
				found     = 1'b1;
				found_ord = OW'(k);
			end
		end
	end

	always_comb begin
		sts.op_free    = op_q;
		sts.init_last  = int'(init_q) == NUM_PAGES - 1;
		sts.alloc_fail = (int'(req_q) >= NUM_ORDERS) || !found;
		sts.page_ok    = pok_q;
		sts.blk_ok     = !fr_rd && or_rd[OW];
		sts.merge_try  = (int'(ord_q) < TOP) && (int'(buddy) < NUM_PAGES);
		sts.buddy_ok   = fr_rd && or_rd[OW] && (or_rd[OW-1:0] == ord_q);
		sts.split_more = ord_q > req_q;
		sts.mark_last  = {1'b0, cnt_q} == ((LW'(1) << ord_q) - LW'(1));
		sts.out_room   = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		fr_we = 1'b0; fr_wa = '0; fr_wd = 1'b0;
		or_we = 1'b0; or_wa = '0; or_wd = '0;
		nx_we = 1'b0; nx_wa = '0; nx_wd = NIL;
		pv_we = 1'b0; pv_wa = '0; pv_wd = NIL;
		case (cmd)
			CMD_INIT: begin
				fr_we = 1'b1; fr_wa = init_q; fr_wd = in_cov;
				or_we = 1'b1; or_wa = init_q; or_wd = {is_head, OW'(TOP)};
				nx_we = 1'b1; nx_wa = init_q; nx_wd = init_next;
				pv_we = 1'b1; pv_wa = init_q; pv_wd = init_prev;
			end
			CMD_UL_FIX: begin
				nx_we = !pv_rd[PW]; nx_wa = pv_rd[PW-1:0]; nx_wd = nx_rd;
				pv_we = !nx_rd[PW]; pv_wa = nx_rd[PW-1:0]; pv_wd = pv_rd;
			end
			CMD_UL_CLR: begin
				nx_we = 1'b1; nx_wa = tgt_q;
				pv_we = 1'b1; pv_wa = tgt_q;
			end
			CMD_PUSH1: begin
				pv_we = 1'b1; pv_wa = tgt_q; pv_wd = tail;
				or_we = 1'b1; or_wa = tgt_q; or_wd = {1'b1, ord_q};
				nx_we = !tail[PW]; nx_wa = tail[PW-1:0]; nx_wd = {1'b0, tgt_q};
			end
			CMD_PUSH2: begin
				nx_we = 1'b1; nx_wa = tgt_q;
			end
			CMD_M_UPD: begin
				or_we = 1'b1;
				or_wa = (tgt_q < pg_q) ? pg_q : tgt_q;
			end
			CMD_MARK: begin
				fr_we = 1'b1; fr_wa = mark_addr; fr_wd = op_q;
				or_we = cnt_q == '0; or_wa = pg_q; or_wd = {1'b1, ord_q};
			end
			default: begin
				fr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_ALLOC;
			req_q       <= '0;
			pok_q       <= 1'b0;
			pg_q        <= '0;
			tgt_q       <= '0;
			cnt_q       <= '0;
			init_q      <= '0;
			ord_q       <= '0;
			rsp_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			page_q      <= '0;
			order_q     <= '0;
			for (int k = 0; k < NUM_ORDERS; k++) begin
				first_q[k] <= (k == TOP && NBLK > 0) ? LW'(0) : NIL;
				last_q[k]  <= (k == TOP && NBLK > 0) ? {1'b0, PW'(COVERED - BLK)} : NIL;
				count_q[k] <= (k == TOP) ? CW'(NBLK) : '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall && cmd != CMD_RESULT && cmd != CMD_FAIL) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_INIT: init_q <= init_q + PW'(1);
				CMD_IDLE: begin
					if (req_valid) begin
						op_q  <= opcode;
						req_q <= req_order;
						pok_q <= int'(page_index) < NUM_PAGES;
						pg_q  <= PW'(page_index);
					end
				end
				CMD_A_SEARCH: ord_q <= found_ord;
				CMD_A_HEAD: begin
					pg_q  <= first_q[lo][PW-1:0];
					tgt_q <= first_q[lo][PW-1:0];
					cnt_q <= '0;
				end
				CMD_F_CHK: ord_q <= or_rd[OW-1:0];
				CMD_M_RD:  tgt_q <= buddy;
				CMD_UL_FIX: begin
					if (pv_rd[PW]) begin
						first_q[lo] <= nx_rd;
					end
					if (nx_rd[PW]) begin
						last_q[lo] <= pv_rd;
					end
					if (count_q[lo] != '0) begin
						count_q[lo] <= count_q[lo] - CW'(1);
					end
				end
				CMD_M_UPD: begin
					if (tgt_q < pg_q) begin
						pg_q <= tgt_q;
					end
					ord_q <= ord_q + OW'(1);
				end
				CMD_F_FINAL: begin
					tgt_q <= pg_q;
					cnt_q <= '0;
				end
				CMD_SPLIT: begin
					if (ord_q > req_q) begin
						ord_q <= ord_q - OW'(1);
						tgt_q <= right;
					end
				end
				CMD_PUSH1: begin
					if (tail[PW]) begin
						first_q[lo] <= {1'b0, tgt_q};
					end
					last_q[lo]  <= {1'b0, tgt_q};
					count_q[lo] <= count_q[lo] + CW'(1);
				end
				CMD_MARK: cnt_q <= cnt_q + PW'(1);
				CMD_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						ok_q        <= 1'b1;
						page_q      <= PAGE_W'(pg_q);
						order_q     <= ord_q;
					end
				end
				CMD_FAIL: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						ok_q        <= 1'b0;
						page_q      <= '0;
						order_q     <= '0;
					end
				end
				default: begin
					init_q <= init_q;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign ok          = ok_q;
	assign block_page  = page_q;
	assign block_order = order_q;
endmodule

FILE: rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy allocator over NUM_PAGES pages with per-order free lists.
// ----------------------------------------------------------------------------
// After reset the block writes every entry of the page memories and takes
// no request until that is done. Requests are then handled one at a time.
// An allocation finds the smallest non-empty free list at or above the
// requested order, unlinks its head, splits it down to the requested order
// while pushing each right half onto its free list, and marks every page of
// the granted block used; a free checks the page, merges with each free
// buddy in turn, pushes the merged block and marks every page of it free.
// The time taken is set by the controller stepping through the page memories
// one access per cycle, and by the sweep that marks each page of a block free
// or used. Results wait in an output register, so the next request is taken
// while a result is still being held.
module buddy_page_allocator #(
	parameter int NUM_PAGES  = 1024,
	parameter int NUM_ORDERS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         opcode,
	input  logic [bpa_pkg::OW-1:0]       req_order,
	input  logic [bpa_pkg::PAGE_W-1:0]   page_index,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         ok,
	output logic [bpa_pkg::PAGE_W-1:0]   block_page,
	output logic [bpa_pkg::OW-1:0]       block_order
);
	import bpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid),
		.sts(sts), .cmd(cmd), .req_stall(req_stall)
	);

	bpa_dp #(.NUM_PAGES(NUM_PAGES), .NUM_ORDERS(NUM_ORDERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_valid(req_valid), .opcode(opcode), .req_order(req_order),
		.page_index(page_index), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
		.ok(ok), .block_page(block_page), .block_order(block_order)
	);
endmodule

FILE: rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Temporal checks on the request and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_assert.svh"

module bpa_checker #(
	parameter int NUM_ORDERS = 10
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic                         ok,
	input logic [bpa_pkg::PAGE_W-1:0]   block_page,
	input logic [bpa_pkg::OW-1:0]       block_order
);
	`BPA_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(block_page) && $stable(ok), "stalled result changed")
	`BPA_CHECK(a_fail_zero, rsp_valid && !ok |-> block_page == 10'd0 && block_order == 4'd0, "refusal with non-zero fields")
	`BPA_CHECK(a_aligned, rsp_valid && ok |-> block_order < NUM_ORDERS && (block_page & ((10'd1 << block_order) - 10'd1)) == 10'd0, "misaligned or oversized block")
	`BPA_CHECK_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "second request taken while busy")
endmodule

bind buddy_page_allocator bpa_checker #(.NUM_ORDERS(NUM_ORDERS)) u_bpa_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .ok(ok),
	.block_page(block_page), .block_order(block_order)
);
